/* hw/rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the stable priority task queue and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int HANDLE_W      = 32;
  localparam int PRIO_IN_W     = 16;
  localparam int PRIO_FIELD_W  = 15;
  localparam int COUNT_FIELD_W = 5;
  localparam int PRIO_WIDE_W   = 31;
  localparam int COUNT_WIDE_W  = 9;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NEGATIVE = 2'd3
  } spq_status_t;

  typedef struct packed {
    logic                        op;
    logic [HANDLE_W-1:0]         task_handle;
    logic signed [PRIO_IN_W-1:0] task_priority;
  } spq_in_t;

  typedef struct packed {
    spq_status_t              status;
    logic [HANDLE_W-1:0]      popped_handle;
    logic [PRIO_FIELD_W-1:0]  popped_priority;
    logic [COUNT_FIELD_W-1:0] entry_count;
  } spq_out_t;

  typedef struct packed {
    logic push_en;
    logic pop_en;
  } spq_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// One queue slot: holds a priority and a handle, keeps, takes the new task,
// or shifts from a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
  parameter int PRIORITY_BITS = 15
) (
  input  wire                          clk,
  input  spq_pkg::spq_ctrl_t           ctrl,
  input  wire                          occupied,
  input  wire  [PRIORITY_BITS-1:0]     new_prio,
  input  wire  [spq_pkg::HANDLE_W-1:0] new_handle,
  input  wire                          left_keep,
  input  wire  [PRIORITY_BITS-1:0]     left_prio,
  input  wire  [spq_pkg::HANDLE_W-1:0] left_handle,
  input  wire  [PRIORITY_BITS-1:0]     right_prio,
  input  wire  [spq_pkg::HANDLE_W-1:0] right_handle,
  output logic                         keep,
  output logic [PRIORITY_BITS-1:0]     prio,
  output logic [spq_pkg::HANDLE_W-1:0] handle
);
  import spq_pkg::*;

  logic [PRIORITY_BITS-1:0] prio_r, prio_nxt;
  logic [HANDLE_W-1:0]      handle_r, handle_nxt;

  // entries at or below the new priority stay in front of it
  assign keep   = occupied && (prio_r <= new_prio);
  assign prio   = prio_r;
  assign handle = handle_r;

  always_comb begin
    prio_nxt   = prio_r;
    handle_nxt = handle_r;
    if (ctrl.push_en && !keep) begin
      if (left_keep) begin
        prio_nxt   = new_prio;
        handle_nxt = new_handle;
      end else begin
        prio_nxt   = left_prio;
        handle_nxt = left_handle;
      end
    end else if (ctrl.pop_en) begin
      prio_nxt   = right_prio;
      handle_nxt = right_handle;
    end
  end

  always_ff @(posedge clk) begin
    prio_r   <= prio_nxt;
    handle_r <= handle_nxt;
  end

endmodule

`default_nettype wire

/* hw/rtl/stable_priority_task_queue.sv */
// ----------------------------------------------------------------------------
// stable_priority_task_queue
// Bounded task queue kept sorted by priority, equal priorities in FIFO order.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one beat per push (op 0) or pop (op 1).
//   out_valid/out_ready return exactly one result beat per input beat:
//   status, popped task and priority on a good pop, and the entry count.
//   The slots form a row of cells; a push compares its priority in every
//   cell at once and the row shifts right behind the insert point, a pop
//   shifts the row left and the head cell delivers the task.
//   The result is registered: it appears in the output register in the
//   cycle after the input beat. Throughput is one item per cycle while
//   no result waits with out_ready low, set by the cell row's compare-and-shift.
//   While a result waits with out_ready low, in_ready drops; it stays high
//   when the waiting result is taken in the same cycle.
//   Reset empties the queue and clears the output register; slot contents
//   are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_task_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int PRIORITY_BITS = 15
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  spq_pkg::spq_in_t   in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output spq_pkg::spq_out_t  out_data
);
  import spq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  spq_out_t      out_data_r, out_data_nxt;

  logic accept, is_neg, is_full, is_empty, push_ok, pop_ok;
  spq_ctrl_t ctrl;

  logic [PRIO_WIDE_W-1:0]   prio_wide, head_wide;
  logic [PRIORITY_BITS-1:0] new_prio;
  logic [COUNT_WIDE_W-1:0]  count_wide;

  logic [PRIORITY_BITS-1:0] cell_prio   [QUEUE_DEPTH];
  logic [HANDLE_W-1:0]      cell_handle [QUEUE_DEPTH];
  logic                     cell_keep   [QUEUE_DEPTH];

  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign accept   = in_valid && in_ready;
  assign is_neg   = in_data.task_priority[PRIO_IN_W-1];
  assign is_full  = (count_r == CW'(QUEUE_DEPTH));
  assign is_empty = (count_r == '0);
  assign push_ok  = accept && (in_data.op == OP_PUSH) && !is_neg && !is_full;
  assign pop_ok   = accept && (in_data.op == OP_POP) && !is_empty;

  assign ctrl.push_en = push_ok;
  assign ctrl.pop_en  = pop_ok;

  assign prio_wide = {{(PRIO_WIDE_W-PRIO_FIELD_W){1'b0}},
                      in_data.task_priority[PRIO_FIELD_W-1:0]};
  assign new_prio  = prio_wide[PRIORITY_BITS-1:0];
  assign head_wide = PRIO_WIDE_W'(cell_prio[0]);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                     lk;
    logic [PRIORITY_BITS-1:0] lp, rp;
    logic [HANDLE_W-1:0]      lh, rh;

    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign lp = new_prio;
      assign lh = in_data.task_handle;
    end else begin : g_left
      assign lk = cell_keep[i-1];
      assign lp = cell_prio[i-1];
      assign lh = cell_handle[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign rp = '0;
      assign rh = '0;
    end else begin : g_right
      assign rp = cell_prio[i+1];
      assign rh = cell_handle[i+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (count_r > CW'(i)),
      .new_prio    (new_prio),
      .new_handle  (in_data.task_handle),
      .left_keep   (lk),
      .left_prio   (lp),
      .left_handle (lh),
      .right_prio  (rp),
      .right_handle(rh),
      .keep        (cell_keep[i]),
      .prio        (cell_prio[i]),
      .handle      (cell_handle[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(1);
    end else if (pop_ok) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign count_wide = COUNT_WIDE_W'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.popped_handle   = '0;
      out_data_nxt.popped_priority = '0;
      out_data_nxt.entry_count     = count_wide[COUNT_FIELD_W-1:0];
      if (in_data.op == OP_PUSH) begin
        if (is_neg) begin
          out_data_nxt.status = ST_NEGATIVE;
        end else if (is_full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          out_data_nxt.status = ST_OK;
        end
      end else begin
        if (is_empty) begin
          out_data_nxt.status = ST_EMPTY;
        end else begin
          out_data_nxt.status          = ST_OK;
          out_data_nxt.popped_handle   = cell_handle[0];
          out_data_nxt.popped_priority = head_wide[PRIO_FIELD_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_data_r  <= '0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/spq_checker.sv */
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the stable priority task queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker #(
  parameter int QUEUE_DEPTH = 16
) (
  input wire               clk,
  input wire               rst_n,
  input wire               in_valid,
  input wire               in_ready,
  input spq_pkg::spq_in_t  in_data,
  input wire               out_valid,
  input wire               out_ready,
  input spq_pkg::spq_out_t out_data
);
  import spq_pkg::*;

  localparam logic [COUNT_WIDE_W-1:0] DEPTH_WIDE = COUNT_WIDE_W'(QUEUE_DEPTH);

  logic in_beat;
  assign in_beat = in_valid && in_ready && (in_data.op == OP_PUSH || in_data.op == OP_POP);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // every accepted item yields a result in the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> out_valid)
    else $error("no result after accepted beat");

  // input stalls only behind a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // failed items carry no task
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.popped_handle == '0 && out_data.popped_priority == '0)
    else $error("failed item carries a task");

  // empty and full reports agree with the count
  a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_data.status != ST_EMPTY || out_data.entry_count == '0) &&
      (out_data.status != ST_FULL ||
       out_data.entry_count == DEPTH_WIDE[COUNT_FIELD_W-1:0]))
    else $error("status disagrees with entry count");

endmodule

bind stable_priority_task_queue spq_checker #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
